>>> src/hkt_pkg.sv
// hkt_pkg: shared constants, codes and controller/datapath handshake types
// for the key-to-dense-id hash table. No dependencies.
`default_nettype none
package hkt_pkg;

  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned IDX_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned HASH_STEPS = KEY_W / 8;
  localparam int unsigned HCNT_W     = $clog2(HASH_STEPS);

  localparam int unsigned IN_TDATA_W  = ((KEY_W + IDX_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((IDX_W + KEY_W + CNT_W + 7) / 8) * 8;

  // chain terminator, never a valid entry
  localparam logic [CNT_W-1:0] NONE_MARK = CNT_W'(CAPACITY);

  localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
  localparam logic [OP_W-1:0] OP_RETRIEVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_ID  = 2'd2;

  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_ID    = 3'd4;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_HASH  = 8'b0000_0100,
    S_HEAD  = 8'b0000_1000,
    S_FETCH = 8'b0001_0000,
    S_WALK  = 8'b0010_0000,
    S_IDRD  = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } ctrl_state_t;

  // source of the result identifier
  typedef enum logic [1:0] {
    RID_ZERO  = 2'd0,
    RID_CUR   = 2'd1,
    RID_COUNT = 2'd2,
    RID_IDENT = 2'd3
  } rid_sel_t;

  // entry RAM read address source
  typedef enum logic [1:0] {
    ERS_IDENT = 2'd0,
    ERS_HEAD  = 2'd1,
    ERS_NEXT  = 2'd2
  } ent_rsel_t;

  typedef struct packed {
    logic              accept;
    logic              clr_step;
    logic              hash_step;
    logic              cur_load_head;
    logic              cur_load_next;
    logic              insert;
    logic              set_res;
    logic [STAT_W-1:0] res_status;
    rid_sel_t          res_id_sel;
    logic              res_key;
    ent_rsel_t         ent_rsel;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic            clr_last;
    logic [OP_W-1:0] in_op;
    logic [OP_W-1:0] op;
    logic            cur_ok;
    logic            key_hit;
    logic            full;
    logic            id_ok;
    logic            out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> src/hkt_ram.sv
// hkt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module hkt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> src/hkt_dp.sv
// hkt_dp: datapath of the hash table - byte-serial modulo, bucket head,
// entry key and entry next RAMs, entry count and result/output registers.
// Depends on hkt_pkg and hkt_ram.
`default_nettype none
module hkt_dp import hkt_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = 1021
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [OP_W-1:0]        in_tuser,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic [STAT_W-1:0]           out_tuser
);

  localparam int unsigned BKT_W = $clog2(NUM_BUCKETS);
  localparam int unsigned RED_W = BKT_W + 8;
  localparam logic [RED_W-1:0] NB_RED = RED_W'(NUM_BUCKETS);

  logic [KEY_W-1:0] in_key;
  logic [IDX_W-1:0] in_ident;

  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  kshift_r;
  logic [OP_W-1:0]   op_r;
  logic [IDX_W-1:0]  ident_r;
  logic [BKT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  cur_r;
  logic [CNT_W-1:0]  head_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [BKT_W-1:0]  clr_idx_r;

  logic [STAT_W-1:0] res_status_r;
  logic [IDX_W-1:0]  res_id_r;
  logic [KEY_W-1:0]  res_key_r;
  logic [IDX_W-1:0]  res_id_nxt;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [IDX_W-1:0]  out_id_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic              head_we;
  logic [BKT_W-1:0]  head_waddr;
  logic [CNT_W-1:0]  head_wdata;
  logic [CNT_W-1:0]  head_rdata;
  logic [IDX_W-1:0]  ent_raddr;
  logic [KEY_W-1:0]  key_rdata;
  logic [CNT_W-1:0]  next_rdata;

  assign in_key   = in_tdata[KEY_W-1:0];
  assign in_ident = in_tdata[KEY_W +: IDX_W];

  // one byte of remainder reduction: (rem*256 + byte) mod NUM_BUCKETS
  function automatic logic [BKT_W-1:0] mod_step(input logic [BKT_W-1:0] rem,
                                                input logic [7:0] byte_in);
    logic [RED_W-1:0] t;
    t = {rem, byte_in};
    for (int k = 7; k >= 0; k--) begin
      if (t >= (NB_RED << k)) begin
        t = t - (NB_RED << k);
      end
    end
    return t[BKT_W-1:0];
  endfunction

  // ---- memories ----
  assign head_we    = cmd.clr_step | cmd.insert;
  assign head_waddr = cmd.clr_step ? clr_idx_r : rem_r;
  assign head_wdata = cmd.clr_step ? NONE_MARK : count_r;

  hkt_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (rem_r),
    .rdata (head_rdata)
  );

  always_comb begin
    case (cmd.ent_rsel)
      ERS_HEAD: ent_raddr = head_rdata[IDX_W-1:0];
      ERS_NEXT: ent_raddr = next_rdata[IDX_W-1:0];
      default:  ent_raddr = in_ident;
    endcase
  end

  hkt_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (cmd.insert),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (key_r),
    .raddr (ent_raddr),
    .rdata (key_rdata)
  );

  // new entry links to the old bucket head
  hkt_ram #(.WIDTH(CNT_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (cmd.insert),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (head_r),
    .raddr (ent_raddr),
    .rdata (next_rdata)
  );

  // ---- control state ----
  assign count_nxt = cmd.insert ? count_r + CNT_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + BKT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- payload ----
  always_comb begin
    case (cmd.res_id_sel)
      RID_CUR:   res_id_nxt = cur_r[IDX_W-1:0];
      RID_COUNT: res_id_nxt = count_r[IDX_W-1:0];
      RID_IDENT: res_id_nxt = ident_r;
      default:   res_id_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r    <= in_key;
      kshift_r <= in_key;
      op_r     <= in_tuser;
      ident_r  <= in_ident;
      rem_r    <= '0;
    end else if (cmd.hash_step) begin
      rem_r    <= mod_step(rem_r, kshift_r[KEY_W-1 -: 8]);
      kshift_r <= kshift_r << 8;
    end
    if (cmd.cur_load_head) begin
      cur_r  <= head_rdata;
      head_r <= head_rdata;
    end else if (cmd.cur_load_next) begin
      cur_r <= next_rdata;
    end
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      res_id_r     <= res_id_nxt;
      res_key_r    <= cmd.res_key ? key_rdata : '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_key_r    <= res_key_r;
      out_cnt_r    <= count_r;
    end
  end

  // ---- status to controller ----
  always_comb begin
    sts.clr_last = (clr_idx_r == BKT_W'(NUM_BUCKETS - 1));
    sts.in_op    = in_tuser;
    sts.op       = op_r;
    sts.cur_ok   = (cur_r < count_r);
    sts.key_hit  = (key_rdata == key_r);
    sts.full     = (count_r == NONE_MARK);
    sts.id_ok    = ({1'b0, ident_r} < count_r);
    sts.out_free = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_TDATA_W'({out_cnt_r, out_key_r, out_id_r});

endmodule
`default_nettype wire

>>> src/hkt_ctrl.sv
// hkt_ctrl: controller state machine of the hash table; sequences the
// clearing pass, hashing, chain walk, insert, identifier read and result hand-off.
// Depends on hkt_pkg.
`default_nettype none
module hkt_ctrl import hkt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  ctrl_state_t       state_r;
  ctrl_state_t       state_nxt;
  logic [HCNT_W-1:0] hcnt_r;
  logic [HCNT_W-1:0] hcnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    hcnt_nxt  = hcnt_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          hcnt_nxt   = '0;
          if (sts.in_op == OP_REGISTER || sts.in_op == OP_RETRIEVE) begin
            state_nxt = S_HASH;
          end else if (sts.in_op == OP_READ_ID) begin
            state_nxt = S_IDRD;
          end else begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_NOT_FOUND;
            cmd.res_id_sel = RID_ZERO;
            state_nxt      = S_RESP;
          end
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        hcnt_nxt      = hcnt_r + HCNT_W'(1);
        if (hcnt_r == HCNT_W'(HASH_STEPS - 1)) begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        // bucket head read in flight
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        cmd.cur_load_head = 1'b1;
        cmd.ent_rsel      = ERS_HEAD;
        state_nxt         = S_WALK;
      end
      S_WALK: begin
        if (!sts.cur_ok) begin
          cmd.set_res    = 1'b1;
          cmd.res_id_sel = RID_ZERO;
          state_nxt      = S_RESP;
          if (sts.op != OP_REGISTER) begin
            cmd.res_status = ST_NOT_FOUND;
          end else if (sts.full) begin
            cmd.res_status = ST_FULL;
          end else begin
            cmd.insert     = 1'b1;
            cmd.res_status = ST_INSERTED;
            cmd.res_id_sel = RID_COUNT;
          end
        end else if (sts.key_hit) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_FOUND;
          cmd.res_id_sel = RID_CUR;
          state_nxt      = S_RESP;
        end else begin
          cmd.cur_load_next = 1'b1;
          cmd.ent_rsel      = ERS_NEXT;
        end
      end
      S_IDRD: begin
        cmd.set_res = 1'b1;
        state_nxt   = S_RESP;
        if (sts.id_ok) begin
          cmd.res_status = ST_FOUND;
          cmd.res_id_sel = RID_IDENT;
          cmd.res_key    = 1'b1;
        end else begin
          cmd.res_status = ST_BAD_ID;
          cmd.res_id_sel = RID_ZERO;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      hcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      hcnt_r  <= hcnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/key_to_dense_id_hash_table_unit.sv
// key_to_dense_id_hash_table_unit: top level of the interning hash table.
// Depends on hkt_pkg, hkt_ctrl, hkt_dp (which uses hkt_ram).
//
//   channel | ports      | tuser          | tdata (low bit up)
//   --------+------------+----------------+------------------------------------
//   input   | in_t*      | opcode[1:0]    | key[63:0], ident_in[73:64], pad
//   result  | out_t*     | status[2:0]    | ident_out[9:0], key_out[73:10],
//           |            |                | entry_count[84:74], pad
//
// After reset the bucket heads are cleared, one per cycle, while in_tready stays
// low. One item is worked on at a time. Register/retrieve run the byte-serial
// key modulo, then read the bucket head and walk the chain, one entry per
// cycle on the entry RAM read port. A result waits in the output register
// while out_tready is low; the next item is accepted meanwhile and stalls
// only at its hand-off.
`default_nettype none
module key_to_dense_id_hash_table_unit import hkt_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = 1021
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // key, ident_in
  input  wire logic [OP_W-1:0]        in_tuser,   // opcode
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // ident_out, key_out, entry_count
  output logic [STAT_W-1:0]           out_tuser   // status
);

  cmd_t cmd;
  sts_t sts;

  hkt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hkt_dp #(.NUM_BUCKETS(NUM_BUCKETS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // no beat is taken while the bucket heads are being cleared
  a_clear_blocks_input: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> !sts.full)
    else $error("insert into full table");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second beat accepted while item in flight");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for key_to_dense_id_hash_table_unit. It keeps its own
// chained-table predictor, drives random and directed register/retrieve/read-id
// beats with random gaps and stalls. Depends on hkt_pkg and the block's RTL.
module tb import hkt_pkg::*; ();

  localparam int unsigned NUM_BUCKETS = 1021;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] ident;
  } intern_req_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  ident;
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  count;
  } intern_res_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]        in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;

  key_to_dense_id_hash_table_unit #(.NUM_BUCKETS(NUM_BUCKETS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state: chain heads, entry keys and links, entry count
  logic [CNT_W-1:0] chain_head [NUM_BUCKETS];
  logic [KEY_W-1:0] slot_key   [CAPACITY];
  logic [CNT_W-1:0] slot_next  [CAPACITY];
  logic [CNT_W-1:0] slot_count;

  intern_req_t pending_reqs[$];
  intern_res_t expected_results[$];
  int unsigned total_reqs;
  int unsigned accepted_cnt;
  int unsigned error_cnt;
  int unsigned cycle_cnt;

  // stimulus-side view of registered keys, used to pick keys and identifiers
  bit               gen_known [logic [KEY_W-1:0]];
  logic [KEY_W-1:0] gen_keys[$];

  function automatic intern_res_t predict_intern(intern_req_t r);
    intern_res_t res;
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] hit;
    int unsigned steps;
    int unsigned b;
    res = '{ST_NOT_FOUND, '0, '0, '0};
    if (r.op == OP_REGISTER || r.op == OP_RETRIEVE) begin
      b = int'(r.key % 64'(NUM_BUCKETS));
      cur = chain_head[b];
      hit = NONE_MARK;
      steps = 0;
      while (cur < slot_count && steps < CAPACITY && hit == NONE_MARK) begin
        if (slot_key[cur] == r.key) hit = cur;
        else cur = slot_next[cur];
        steps++;
      end
      if (hit != NONE_MARK) begin
        res.status = ST_FOUND;
        res.ident = hit[IDX_W-1:0];
      end else if (r.op == OP_REGISTER) begin
        if (slot_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          slot_key[slot_count] = r.key;
          slot_next[slot_count] = chain_head[b];
          chain_head[b] = slot_count;
          res.status = ST_INSERTED;
          res.ident = slot_count[IDX_W-1:0];
          slot_count = slot_count + 1'b1;
        end
      end
    end else if (r.op == OP_READ_ID) begin
      if (CNT_W'(r.ident) < slot_count) begin
        res.status = ST_FOUND;
        res.ident = r.ident;
        res.key = slot_key[r.ident];
      end else begin
        res.status = ST_BAD_ID;
      end
    end
    res.count = slot_count;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
    $display("%0t: %s got %0h want %0h", $time, what, got, want);
    error_cnt++;
  endtask

  task automatic queue_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, logic [IDX_W-1:0] ident);
    intern_req_t r;
    r = '{op, key, ident};
    pending_reqs.push_back(r);
    if (op == OP_REGISTER && !gen_known.exists(key) && gen_keys.size() < CAPACITY) begin
      gen_known[key] = 1'b1;
      gen_keys.push_back(key);
    end
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_W-1:0] known_key();
    if (gen_keys.size() == 0) return rand_key();
    return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
  endfunction

  // driver: one request beat at a time, random gap after each accept
  intern_req_t drive_req;
  logic        in_beat = 1'b0;
  logic        out_beat = 1'b0;
  int unsigned in_gap = 0;
  bit          in_calm = 1'b0;
  int unsigned out_stall = 0;
  bit          out_calm = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_beat) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        drive_req = pending_reqs.pop_front();
        in_tuser  <= drive_req.op;
        in_tdata  <= IN_TDATA_W'({drive_req.ident, drive_req.key});
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 7);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_beat) begin
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, 7);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: predict on request accept, check each result beat
  always @(posedge clk) begin
    intern_res_t want;
    in_beat  <= rst_n && in_tvalid && in_tready;
    out_beat <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      expected_results.push_back(predict_intern(drive_req));
      accepted_cnt++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", KEY_W'(out_tuser), '0);
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.status)
          report_mismatch("status", KEY_W'(out_tuser), KEY_W'(want.status));
        if (out_tdata[IDX_W-1:0] !== want.ident)
          report_mismatch("ident_out", KEY_W'(out_tdata[IDX_W-1:0]), KEY_W'(want.ident));
        if (out_tdata[IDX_W+KEY_W-1:IDX_W] !== want.key)
          report_mismatch("key_out", out_tdata[IDX_W+KEY_W-1:IDX_W], want.key);
        if (out_tdata[IDX_W+KEY_W+CNT_W-1:IDX_W+KEY_W] !== want.count)
          report_mismatch("entry_count", KEY_W'(out_tdata[IDX_W+KEY_W+CNT_W-1:IDX_W+KEY_W]),
                          KEY_W'(want.count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned extra;
    int unsigned pick;
    int unsigned new_pct;
    logic [KEY_W-1:0] k;
    logic [IDX_W-1:0] id;
    for (int b = 0; b < NUM_BUCKETS; b++) chain_head[b] = NONE_MARK;
    for (int e = 0; e < CAPACITY; e++) begin
      slot_key[e] = '0;
      slot_next[e] = NONE_MARK;
    end
    slot_count = '0;
    accepted_cnt = 0;
    error_cnt = 0;
    cycle_cnt = 0;

    // directed: empty table, extremes, same-bucket chain, unused opcode
    queue_req(OP_RETRIEVE, 64'd5, '0);
    queue_req(OP_READ_ID, '0, '0);
    queue_req(OP_UNUSED, '1, '1);
    queue_req(OP_REGISTER, '0, '0);
    queue_req(OP_REGISTER, '1, '1);
    queue_req(OP_REGISTER, '0, '1);
    queue_req(OP_RETRIEVE, '1, '0);
    queue_req(OP_READ_ID, '1, 10'd1);
    queue_req(OP_READ_ID, '0, 10'd2);
    queue_req(OP_READ_ID, '0, '1);
    queue_req(OP_REGISTER, 64'd7, '0);
    queue_req(OP_REGISTER, 64'd7 + 64'(NUM_BUCKETS), '0);
    queue_req(OP_REGISTER, 64'd7 + 64'(2 * NUM_BUCKETS), '0);
    queue_req(OP_RETRIEVE, 64'd7, '0);  // tail of a three-entry chain
    queue_req(OP_RETRIEVE, 64'd7 + 64'(3 * NUM_BUCKETS), '0);
    queue_req(OP_REGISTER, 64'd7 + 64'(NUM_BUCKETS), '0);
    queue_req(OP_REGISTER, 64'h8000_0000_0000_0000, '0);
    queue_req(OP_READ_ID, '0, 10'd5);
    queue_req(OP_UNUSED, '0, '0);
    queue_req(OP_REGISTER, '1 - 64'(NUM_BUCKETS), 10'h155);
    queue_req(OP_RETRIEVE, '1 - 64'(NUM_BUCKETS), '0);
    queue_req(OP_READ_ID, '0, 10'd6);

    // random: mostly new keys until the table fills, then a mixed tail
    extra = 0;
    while (extra < 50) begin
      new_pct = (gen_keys.size() < CAPACITY) ? 92 : 30;
      pick = $urandom_range(0, 99);
      id = 10'($urandom);
      if (pick < new_pct) begin
        if ($urandom_range(0, 4) == 0)
          k = known_key() + 64'(NUM_BUCKETS) * 64'($urandom_range(1, 4000));
        else
          k = rand_key();
        queue_req(OP_REGISTER, k, id);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          queue_req(OP_REGISTER, known_key(), id);
        end else if (pick < 50) begin
          queue_req(OP_RETRIEVE, known_key(), id);
        end else if (pick < 62) begin
          queue_req(OP_RETRIEVE, rand_key(), id);
        end else if (pick < 90) begin
          if ($urandom_range(0, 3) != 0 && gen_keys.size() != 0)
            id = 10'($urandom_range(0, gen_keys.size() - 1));
          queue_req(OP_READ_ID, rand_key(), id);
        end else begin
          queue_req(OP_UNUSED, rand_key(), id);
        end
      end
      if (gen_keys.size() == CAPACITY) extra++;
    end
    total_reqs = pending_reqs.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total_reqs || expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
